// File: sv/blpf_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the line-drawing page frame store
package blpf_pkg;

    localparam int DISPLAY_WIDTH  = 128;
    localparam int DISPLAY_HEIGHT = 64;
    localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
    localparam int STORE_SIZE     = DISPLAY_WIDTH * PAGE_COUNT;
    localparam int ADDR_W         = $clog2(STORE_SIZE);

    localparam int FIELD_W  = 10;   // input coordinate and index width
    localparam int COORD_W  = 11;   // one guard bit for stepping
    localparam int DELTA_W  = 10;   // absolute coordinate difference
    localparam int ERR_W    = 14;   // bresenham error term, signed
    localparam int COUNT_W  = 8;
    localparam int BYTE_W   = 8;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    typedef enum logic [1:0] {
        KIND_LINE  = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_PIX,
        ST_WRITE,
        ST_READ,
        ST_FINISH
    } state_t;

endpackage

// File: sv/bresenham_line_page_framebuffer.sv
`timescale 1ns / 1ps
// top level: page frame store with a bresenham line walker, clear and read
// line item: setup, then a read-modify-write on the single ram per on-screen pixel;
//   off-screen pixels are stepped over without a ram access
// read item: a registered ram read; clear: zeroes STORE_SIZE bytes (1024 at 128x64)
// one item in flight; s_tready is low until its result is in the output register
// after aresetn the store is zeroed by a pass over every address, s_tready low meanwhile
module bresenham_line_page_framebuffer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // x_start[9:0] y_start[19:10] x_end[29:20] y_end[39:30]
    // pen_color[40] read_index[50:41], rest zero
    input  logic [blpf_pkg::S_TDATA_W-1:0]  s_tdata,
    // kind[1:0]
    input  logic [blpf_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_byte[7:0] pixels_written[15:8]
    output logic [blpf_pkg::M_TDATA_W-1:0]  m_tdata
);

    import blpf_pkg::*;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]         clr_cnt_reg, clr_cnt_next;
    logic                      clr_item_reg, clr_item_next;
    logic signed [COORD_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [COORD_W-1:0] xe_reg, xe_next, ye_reg, ye_next;
    logic [DELTA_W-1:0]        dx_reg, dx_next, dy_reg, dy_next;
    logic                      sx_neg_reg, sx_neg_next, sy_neg_reg, sy_neg_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic                      pen_reg, pen_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic [BYTE_W-1:0]         byte_reg, byte_next;
    logic                      m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]      m_data_reg, m_data_next;

    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [BYTE_W-1:0] wr_data, rd_data;

    kind_t                     in_kind;
    logic [FIELD_W-1:0]        in_index;
    logic signed [COORD_W-1:0] diff_x, diff_y;
    logic [DELTA_W-1:0]        abs_x, abs_y;

    logic                      on_screen;
    logic [ADDR_W-1:0]         pix_addr;
    logic [BYTE_W-1:0]         pix_mask;
    logic signed [ERR_W-1:0]   e2, dx_s, dy_s, err_step;
    logic                      move_x, move_y, step_done;
    logic signed [COORD_W-1:0] x_step, y_step;

    blpf_ram #(
        .DATA_W (BYTE_W),
        .DEPTH  (STORE_SIZE)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_kind  = kind_t'(s_tuser[1:0]);
    assign in_index = s_tdata[50:41];

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // setup arithmetic on the latched end points
    assign diff_x = xe_reg - x_reg;
    assign diff_y = ye_reg - y_reg;
    assign abs_x  = diff_x[COORD_W-1] ? DELTA_W'(-diff_x) : DELTA_W'(diff_x);
    assign abs_y  = diff_y[COORD_W-1] ? DELTA_W'(-diff_y) : DELTA_W'(diff_y);

    // pixel address and bit for the current walker position
    assign on_screen = !x_reg[COORD_W-1] && !y_reg[COORD_W-1]
                    && (x_reg < COORD_W'(DISPLAY_WIDTH))
                    && (y_reg < COORD_W'(DISPLAY_HEIGHT));
    assign pix_addr = ADDR_W'(ADDR_W'(y_reg[COORD_W-2:3]) * ADDR_W'(DISPLAY_WIDTH))
                    + ADDR_W'(x_reg[COORD_W-2:0]);
    assign pix_mask = BYTE_W'(1) << y_reg[2:0];

    // one bresenham step, shared by the off-screen and write states
    assign dx_s      = ERR_W'(dx_reg);
    assign dy_s      = ERR_W'(dy_reg);
    assign e2        = err_reg <<< 1;
    assign move_x    = e2 > -dy_s;
    assign move_y    = e2 < dx_s;
    assign err_step  = err_reg - (move_x ? dy_s : ERR_W'(0))
                     + (move_y ? dx_s : ERR_W'(0));
    assign x_step    = move_x ? (sx_neg_reg ? x_reg - COORD_W'(1) : x_reg + COORD_W'(1))
                              : x_reg;
    assign y_step    = move_y ? (sy_neg_reg ? y_reg - COORD_W'(1) : y_reg + COORD_W'(1))
                              : y_reg;
    assign step_done = (x_reg == xe_reg) && (y_reg == ye_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            clr_item_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_item_reg <= clr_item_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        xe_reg     <= xe_next;
        ye_reg     <= ye_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        sx_neg_reg <= sx_neg_next;
        sy_neg_reg <= sy_neg_next;
        err_reg    <= err_next;
        pen_reg    <= pen_next;
        count_reg  <= count_next;
        byte_reg   <= byte_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_item_next = clr_item_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        xe_next       = xe_reg;
        ye_next       = ye_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        sx_neg_next   = sx_neg_reg;
        sy_neg_next   = sy_neg_reg;
        err_next      = err_reg;
        pen_next      = pen_reg;
        count_next    = count_reg;
        byte_next     = byte_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;

        s_tready = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = pix_addr;
        wr_data  = '0;
        rd_en    = 1'b0;
        rd_addr  = pix_addr;

        case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = '0;
                if (clr_cnt_reg == ADDR_W'(STORE_SIZE - 1)) begin
                    clr_cnt_next  = '0;
                    clr_item_next = 1'b0;
                    state_next    = clr_item_reg ? ST_FINISH : ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    byte_next  = '0;
                    count_next = '0;
                    x_next     = {s_tdata[9],  s_tdata[9:0]};
                    y_next     = {s_tdata[19], s_tdata[19:10]};
                    xe_next    = {s_tdata[29], s_tdata[29:20]};
                    ye_next    = {s_tdata[39], s_tdata[39:30]};
                    pen_next   = s_tdata[40];
                    case (in_kind)
                        KIND_LINE: begin
                            state_next = ST_SETUP;
                        end
                        KIND_CLEAR: begin
                            clr_cnt_next  = '0;
                            clr_item_next = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        KIND_READ: begin
                            if (32'(in_index) < STORE_SIZE) begin
                                rd_en      = 1'b1;
                                rd_addr    = ADDR_W'(in_index);
                                state_next = ST_READ;
                            end else begin
                                state_next = ST_FINISH;
                            end
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_SETUP: begin
                dx_next     = abs_x;
                dy_next     = abs_y;
                sx_neg_next = !(x_reg < xe_reg);
                sy_neg_next = !(y_reg < ye_reg);
                err_next    = ERR_W'(abs_x) - ERR_W'(abs_y);
                state_next  = ST_PIX;
            end
            ST_PIX: begin
                if (on_screen) begin
                    rd_en      = 1'b1;
                    state_next = ST_WRITE;
                end else if (step_done) begin
                    state_next = ST_FINISH;
                end else begin
                    x_next   = x_step;
                    y_next   = y_step;
                    err_next = err_step;
                end
            end
            ST_WRITE: begin
                wr_en   = 1'b1;
                wr_data = pen_reg ? (rd_data | pix_mask) : (rd_data & ~pix_mask);
                if (count_reg != {COUNT_W{1'b1}}) begin
                    count_next = count_reg + COUNT_W'(1);
                end
                if (step_done) begin
                    state_next = ST_FINISH;
                end else begin
                    x_next     = x_step;
                    y_next     = y_step;
                    err_next   = err_step;
                    state_next = ST_PIX;
                end
            end
            ST_READ: begin
                byte_next  = rd_data;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // output register frees up when the previous word is taken
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {count_reg, byte_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/blpf_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram with registered read
module blpf_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// self-checking bench for the page frame store: line walks, clears and byte reads
module tb;
    import blpf_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 510;
    localparam int HOLD_AT        = 100;   // result index where the long receiver stall starts
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 50;

    typedef struct {
        kind_t             kind;
        logic signed [9:0] x_start;
        logic signed [9:0] y_start;
        logic signed [9:0] x_end;
        logic signed [9:0] y_end;
        logic              pen_color;
        logic [9:0]        read_index;
    } draw_item_t;

    typedef struct {
        logic [7:0] read_byte;
        logic [7:0] pixels_written;
    } frame_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    draw_item_t    item_backlog[$];
    frame_result_t pending_results[$];
    logic [7:0]    frame_copy[STORE_SIZE];

    draw_item_t on_offer;
    int send_gap = 0;
    int tx_calm = 0;
    int rx_calm = 0;
    int stall_left = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    int mismatch_count = 0;
    int last_drawn_index = 0;

    bresenham_line_page_framebuffer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        foreach (frame_copy[i]) frame_copy[i] = '0;
    end

    // applies one item to the shadow frame store and returns its result
    function automatic frame_result_t predict_result(input draw_item_t it);
        frame_result_t r;
        int x, y, xe, ye, dx, dy, sx, sy, err, e2, count, idx;
        r.read_byte = '0;
        r.pixels_written = '0;
        case (it.kind)
            KIND_LINE: begin
                x = it.x_start;
                y = it.y_start;
                xe = it.x_end;
                ye = it.y_end;
                dx = (xe > x) ? xe - x : x - xe;
                dy = (ye > y) ? ye - y : y - ye;
                sx = (x < xe) ? 1 : -1;
                sy = (y < ye) ? 1 : -1;
                err = dx - dy;
                count = 0;
                forever begin
                    if (x >= 0 && x < DISPLAY_WIDTH && y >= 0 && y < DISPLAY_HEIGHT) begin
                        idx = (y / 8) * DISPLAY_WIDTH + x;
                        frame_copy[idx][y % 8] = it.pen_color;
                        count++;
                    end
                    if (x == xe && y == ye) break;
                    e2 = 2 * err;
                    if (e2 > -dy) begin
                        err -= dy;
                        x += sx;
                    end
                    if (e2 < dx) begin
                        err += dx;
                        y += sy;
                    end
                end
                r.pixels_written = (count > 255) ? 8'd255 : 8'(count);
            end
            KIND_CLEAR: begin
                foreach (frame_copy[i]) frame_copy[i] = '0;
            end
            KIND_READ: begin
                if (it.read_index < STORE_SIZE) r.read_byte = frame_copy[it.read_index];
            end
            default: ;
        endcase
        return r;
    endfunction

    // wait length per word, with occasional runs of back-to-back words
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) calm_left = $urandom_range(10, 40);
        return $urandom_range(0, 10);
    endfunction

    // mostly near the screen, sometimes anywhere, sometimes an extreme
    function automatic int pick_coord(input int span);
        case ($urandom_range(0, 9))
            0: return int'($urandom_range(0, 1023)) - 512;
            1: begin
                case ($urandom_range(0, 3))
                    0: return -512;
                    1: return 511;
                    2: return -1;
                    default: return span;
                endcase
            end
            default: return int'($urandom_range(0, span + 15)) - 8;
        endcase
    endfunction

    // every field random so unused fields toggle too
    function automatic draw_item_t junk_item(input kind_t k);
        draw_item_t it;
        it.kind = k;
        it.x_start = 10'($urandom_range(0, 1023));
        it.y_start = 10'($urandom_range(0, 1023));
        it.x_end = 10'($urandom_range(0, 1023));
        it.y_end = 10'($urandom_range(0, 1023));
        it.pen_color = 1'($urandom_range(0, 1));
        it.read_index = 10'($urandom_range(0, 1023));
        return it;
    endfunction

    task automatic add_line(input int x0, input int y0, input int x1, input int y1,
                            input bit pen);
        draw_item_t it;
        it = junk_item(KIND_LINE);
        it.x_start = 10'(x0);
        it.y_start = 10'(y0);
        it.x_end = 10'(x1);
        it.y_end = 10'(y1);
        it.pen_color = pen;
        if (x0 >= 0 && x0 < DISPLAY_WIDTH && y0 >= 0 && y0 < DISPLAY_HEIGHT)
            last_drawn_index = (y0 / 8) * DISPLAY_WIDTH + x0;
        item_backlog.push_back(it);
    endtask

    task automatic add_read(input int idx);
        draw_item_t it;
        it = junk_item(KIND_READ);
        it.read_index = 10'(idx);
        item_backlog.push_back(it);
    endtask

    task automatic add_kind(input kind_t k);
        item_backlog.push_back(junk_item(k));
    endtask

    // sender: one word in flight, held until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_results.push_back(predict_result(on_offer));
                send_gap = draw_gap(tx_calm);
            end
            if (!(s_tvalid && !s_tready)) begin
                if (send_gap > 0 || item_backlog.size() == 0) begin
                    s_tvalid <= 1'b0;
                    if (send_gap > 0) send_gap--;
                end else begin
                    on_offer = item_backlog.pop_front();
                    s_tdata <= {5'd0, on_offer.read_index, on_offer.pen_color,
                                on_offer.y_end, on_offer.x_end,
                                on_offer.y_start, on_offer.x_start};
                    s_tuser <= on_offer.kind;
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // receiver and checker; stalls count only while a result is waiting
    always @(posedge aclk) begin
        frame_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b1;
            stall_left = 0;
        end else if (m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected word: expected none actual %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[7:0] !== want.read_byte) begin
                    $display("%0t read_byte mismatch: expected %h actual %h",
                             $time, want.read_byte, m_tdata[7:0]);
                    mismatch_count++;
                end
                if (m_tdata[15:8] !== want.pixels_written) begin
                    $display("%0t pixels_written mismatch: expected %0d actual %0d",
                             $time, want.pixels_written, m_tdata[15:8]);
                    mismatch_count++;
                end
            end
            stall_left = (results_seen == HOLD_AT) ? HOLD_CYCLES : draw_gap(rx_calm);
            m_tready <= (stall_left == 0);
        end else if (!m_tready && m_tvalid) begin
            if (stall_left > 0) stall_left--;
            if (stall_left == 0) m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int counted, roll, x0, y0;

        // points at the corners, full-width and full-height lines, diagonals
        add_line(0, 0, 0, 0, 1'b1);
        add_line(127, 63, 127, 63, 1'b1);
        add_read(0);
        add_read(1023);
        add_line(0, 10, 127, 10, 1'b1);
        add_line(5, 0, 5, 63, 1'b1);
        add_line(0, 0, 63, 63, 1'b1);
        add_line(100, 60, 90, 2, 1'b1);
        // erase part of the horizontal line, then an erase on a blank pixel
        add_line(30, 10, 10, 10, 1'b0);
        add_read(148);
        add_read(168);
        add_line(40, 20, 40, 20, 1'b0);
        // walks that leave and re-enter the screen, and ones that never touch it
        add_line(-512, -512, 511, 511, 1'b1);
        add_line(-1, 5, -1, 5, 1'b1);
        add_line(200, -300, 511, -512, 1'b1);
        add_line(-512, 511, 511, -512, 1'b0);
        add_kind(KIND_NONE);
        add_read(7 * DISPLAY_WIDTH + 63);
        add_kind(KIND_CLEAR);
        add_read(168);
        add_line(511, 511, -512, -512, 1'b1);
        add_read(0);

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                x0 = pick_coord(DISPLAY_WIDTH);
                y0 = pick_coord(DISPLAY_HEIGHT);
                if ($urandom_range(0, 4) == 0)
                    add_line(x0, y0, x0, y0, 1'($urandom_range(0, 3) != 0));
                else
                    add_line(x0, y0, pick_coord(DISPLAY_WIDTH), pick_coord(DISPLAY_HEIGHT),
                             1'($urandom_range(0, 3) != 0));
                counted++;
            end else if (roll < 93) begin
                // half the reads land on a byte a recent line started in
                if ($urandom_range(0, 1) == 0) add_read(last_drawn_index);
                else add_read($urandom_range(0, 1023));
                counted++;
            end else if (roll < 96) begin
                add_kind(KIND_CLEAR);
                counted++;
            end else begin
                add_kind(KIND_NONE);
            end
        end

        while (item_backlog.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $display("%0t missing words: expected %0d more, actual none",
                     $time, pending_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
